@@ hw/rtl/bap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer pool slot allocator package
// Shared types, request and status codes, and reset constants.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 16;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned CAP_W = 20;

  localparam logic [HANDLE_W-1:0] HANDLE_BASE = 32'h4800_0000;

  localparam logic [2:0] REQ_GET      = 3'd0;
  localparam logic [2:0] REQ_RELEASE  = 3'd1;
  localparam logic [2:0] REQ_DISCARD  = 3'd2;
  localparam logic [2:0] REQ_FREEZE   = 3'd3;
  localparam logic [2:0] REQ_UNFREEZE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_WRONG   = 2'd3;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [CAP_W-1:0]    req_capacity;
    logic [HANDLE_W-1:0] req_handle;
  } bap_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic [CAP_W-1:0]    out_capacity;
    logic                already_mapped;
    logic [1:0]          status;
  } bap_out_t;

  typedef struct packed {
    logic                valid;
    logic                owned;
    logic                frozen;
    logic                mapped;
    logic [HANDLE_W-1:0] handle;
    logic [CAP_W-1:0]    capacity;
  } bap_slot_t;

endpackage
`default_nettype wire

@@ hw/rtl/bap_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer pool slot cell
// Holds one slot record and passes it to its neighbor on every shift cycle.
// ----------------------------------------------------------------------------
module bap_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire bap_pkg::bap_slot_t rec_in,
  output bap_pkg::bap_slot_t     rec_out
);

  logic valid_r, owned_r, frozen_r, mapped_r;
  logic [bap_pkg::HANDLE_W-1:0] handle_r;
  logic [bap_pkg::CAP_W-1:0]    capacity_r;

  // Flags reset so an empty pool reads as all free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      owned_r  <= 1'b0;
      frozen_r <= 1'b0;
      mapped_r <= 1'b0;
    end else if (shift_en) begin
      valid_r  <= rec_in.valid;
      owned_r  <= rec_in.owned;
      frozen_r <= rec_in.frozen;
      mapped_r <= rec_in.mapped;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      handle_r   <= rec_in.handle;
      capacity_r <= rec_in.capacity;
    end
  end

  always_comb begin
    rec_out.valid    = valid_r;
    rec_out.owned    = owned_r;
    rec_out.frozen   = frozen_r;
    rec_out.mapped   = mapped_r;
    rec_out.handle   = handle_r;
    rec_out.capacity = capacity_r;
  end

endmodule
`default_nettype wire

@@ hw/rtl/buffer_pool_slot_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A request is taken only in the idle state. The slot ring then rotates once to scan and
// once more to write back, and the result is loaded into the output register, so a new
// request is taken only after the previous one is through both rotations.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears all slot flags and loads the handle counter
// with 0x48000000; slot handles and capacities are not reset.
// ----------------------------------------------------------------------------
// Buffer pool slot allocator
// Ring of slot cells rotated past a head controller that scans and updates.
// ----------------------------------------------------------------------------
module buffer_pool_slot_allocator #(
  parameter int unsigned POOL_SLOTS = bap_pkg::POOL_SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bap_pkg::bap_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bap_pkg::bap_out_t     out_data
);

  localparam int unsigned PW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(POOL_SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          shift_en;

  bap_pkg::bap_in_t  req_r;
  bap_pkg::bap_out_t res_r, res_nxt, err_res, out_data_r;
  logic              out_valid_r;

  logic [PW-1:0]                best_r, free_r, match_r;
  logic [bap_pkg::CAP_W-1:0]    best_cap_r;
  logic                         best_found_r, free_found_r, match_found_r;
  logic [bap_pkg::HANDLE_W-1:0] next_handle_r, new_handle;

  bap_pkg::bap_slot_t ring [POOL_SLOTS];
  bap_pkg::bap_slot_t head, wrap_rec;

  logic          is_get, type_ok, target_ok, hit;
  logic [PW-1:0] target;

  assign head     = ring[0];
  assign shift_en = (state_r == S_SCAN) || (state_r == S_APPLY);

  // The ring shifts toward cell 0; the head record re-enters at the far end.
  genvar gi;
  generate
    for (gi = 0; gi < POOL_SLOTS; gi++) begin : g_cell
      if (gi == POOL_SLOTS - 1) begin : g_last
        bap_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .rec_in   (wrap_rec),
          .rec_out  (ring[gi])
        );
      end else begin : g_mid
        bap_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .rec_in   (ring[gi+1]),
          .rec_out  (ring[gi])
        );
      end
    end
  endgenerate

  assign is_get     = (req_r.req_type == bap_pkg::REQ_GET);
  assign type_ok    = (req_r.req_type <= bap_pkg::REQ_UNFREEZE);
  assign target     = is_get ? (best_found_r ? best_r : free_r) : match_r;
  assign target_ok  = is_get ? (best_found_r || free_found_r) : (type_ok && match_found_r);
  assign hit        = (state_r == S_APPLY) && (pos_r == target) && target_ok;
  assign new_handle = next_handle_r + bap_pkg::HANDLE_W'(1);

  // Update of the targeted slot as it passes the head during the second rotation.
  always_comb begin
    wrap_rec = head;
    res_nxt  = res_r;
    if (hit) begin
      res_nxt.out_handle     = req_r.req_handle;
      res_nxt.out_capacity   = head.capacity;
      res_nxt.already_mapped = head.mapped;
      res_nxt.status         = bap_pkg::ST_OK;
      case (req_r.req_type)
        bap_pkg::REQ_GET: begin
          if (best_found_r) begin
            wrap_rec.owned     = 1'b1;
            res_nxt.out_handle = head.handle;
          end else begin
            wrap_rec.valid         = 1'b1;
            wrap_rec.owned         = 1'b1;
            wrap_rec.frozen        = 1'b0;
            wrap_rec.mapped        = 1'b0;
            wrap_rec.handle        = new_handle;
            wrap_rec.capacity      = req_r.req_capacity;
            res_nxt.out_handle     = new_handle;
            res_nxt.out_capacity   = req_r.req_capacity;
            res_nxt.already_mapped = 1'b0;
          end
        end
        bap_pkg::REQ_RELEASE: begin
          if (head.owned) begin
            wrap_rec.owned         = 1'b0;
            wrap_rec.mapped        = 1'b1;
            res_nxt.already_mapped = 1'b1;
          end else begin
            res_nxt.out_capacity   = '0;
            res_nxt.already_mapped = 1'b0;
            res_nxt.status         = bap_pkg::ST_WRONG;
          end
        end
        bap_pkg::REQ_DISCARD: begin
          wrap_rec.valid         = 1'b0;
          wrap_rec.owned         = 1'b0;
          wrap_rec.frozen        = 1'b0;
          wrap_rec.mapped        = 1'b0;
          res_nxt.already_mapped = 1'b0;
        end
        bap_pkg::REQ_FREEZE: begin
          if (!head.frozen) begin
            wrap_rec.frozen = 1'b1;
          end else begin
            res_nxt.out_capacity   = '0;
            res_nxt.already_mapped = 1'b0;
            res_nxt.status         = bap_pkg::ST_WRONG;
          end
        end
        bap_pkg::REQ_UNFREEZE: begin
          if (head.frozen) begin
            wrap_rec.frozen = 1'b0;
          end else begin
            res_nxt.out_capacity   = '0;
            res_nxt.already_mapped = 1'b0;
            res_nxt.status         = bap_pkg::ST_WRONG;
          end
        end
        default: begin
          res_nxt.status = bap_pkg::ST_WRONG;
        end
      endcase
    end
  end

  // Result for requests that found no slot to act on.
  always_comb begin
    err_res.out_handle     = req_r.req_handle;
    err_res.out_capacity   = '0;
    err_res.already_mapped = 1'b0;
    if (is_get) begin
      err_res.out_handle = '0;
      err_res.status     = bap_pkg::ST_FULL;
    end else if (!type_ok) begin
      err_res.status = bap_pkg::ST_WRONG;
    end else begin
      err_res.status = bap_pkg::ST_UNKNOWN;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        pos_nxt = pos_r + PW'(1);
        if (pos_r == LAST_POS) begin
          pos_nxt   = '0;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        pos_nxt = pos_r + PW'(1);
        if (pos_r == LAST_POS) begin
          pos_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= '0;
      next_handle_r <= bap_pkg::HANDLE_BASE;
      best_found_r  <= 1'b0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (state_r == S_IDLE && in_valid) begin
        best_found_r  <= 1'b0;
        free_found_r  <= 1'b0;
        match_found_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        if (!head.valid) begin
          if (!free_found_r) begin
            free_found_r <= 1'b1;
          end
        end else if (!head.owned && !head.frozen &&
                     head.capacity >= req_r.req_capacity &&
                     (!best_found_r || head.capacity > best_cap_r)) begin
          best_found_r <= 1'b1;
        end
        if (head.valid && head.handle == req_r.req_handle && !match_found_r) begin
          match_found_r <= 1'b1;
        end
      end
      if (hit && is_get && !best_found_r) begin
        next_handle_r <= new_handle;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    if (state_r == S_SCAN) begin
      if (!head.valid) begin
        if (!free_found_r) begin
          free_r <= pos_r;
        end
      end else if (!head.owned && !head.frozen &&
                   head.capacity >= req_r.req_capacity &&
                   (!best_found_r || head.capacity > best_cap_r)) begin
        best_r     <= pos_r;
        best_cap_r <= head.capacity;
      end
      if (head.valid && head.handle == req_r.req_handle && !match_found_r) begin
        match_r <= pos_r;
      end
    end
    res_r <= res_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r <= target_ok ? res_r : err_res;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_counter_only_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_APPLY) |=> $stable(next_handle_r))
    else $error("handle counter changed outside the update pass");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished transaction was not presented");

  a_pos_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> (pos_r == '0))
    else $error("ring position not parked at zero");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool slot allocator testbench
// Sends get, release, discard, freeze, unfreeze and undefined requests. It
// predicts every result from its own copy of the slot pool and checks each
// result transaction field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import bap_pkg::*;

  localparam int SLOTS = POOL_SLOTS_DEF;
  localparam logic [2:0] REQ_UNDEFINED = 3'd7;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

  typedef enum {PICK_ANY, PICK_OWNED, PICK_FROZEN, PICK_THAWED} pick_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bap_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bap_out_t out_data;

  // Predicted pool contents.
  logic                pool_live [SLOTS] = '{default: 1'b0};
  logic                pool_owned [SLOTS] = '{default: 1'b0};
  logic                pool_frozen [SLOTS] = '{default: 1'b0};
  logic                pool_mapped [SLOTS] = '{default: 1'b0};
  logic [HANDLE_W-1:0] pool_handle [SLOTS] = '{default: '0};
  logic [CAP_W-1:0]    pool_size [SLOTS] = '{default: '0};
  logic [HANDLE_W-1:0] last_handle = HANDLE_BASE;

  bap_out_t    pending_results[$];
  bap_out_t    oldest_result;
  int unsigned mismatches = 0;
  bit          in_idle_on = 1'b0;
  bit          out_idle_on = 1'b0;
  int unsigned stall_budget = 0;

  buffer_pool_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the predicted pool and returns its result.
  function automatic bap_out_t predict_result(bap_in_t req);
    bap_out_t res;
    int best;
    int vacant;
    int hit;
    res = '0;
    res.out_handle = req.req_handle;
    res.status = ST_OK;
    if (req.req_type == REQ_GET) begin
      best = -1;
      vacant = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!pool_live[i]) begin
          if (vacant < 0) vacant = i;
        end else if (!pool_owned[i] && !pool_frozen[i] && pool_size[i] >= req.req_capacity) begin
          if (best < 0 || pool_size[i] > pool_size[best]) best = i;
        end
      end
      if (best < 0 && vacant < 0) begin
        res.out_handle = '0;
        res.status = ST_FULL;
        return res;
      end
      if (best < 0) begin
        last_handle = last_handle + 1'b1;
        best = vacant;
        pool_live[best] = 1'b1;
        pool_handle[best] = last_handle;
        pool_size[best] = req.req_capacity;
        pool_frozen[best] = 1'b0;
        pool_mapped[best] = 1'b0;
      end
      pool_owned[best] = 1'b1;
      res.out_handle = pool_handle[best];
      res.out_capacity = pool_size[best];
      res.already_mapped = pool_mapped[best];
      return res;
    end
    if (req.req_type > REQ_UNFREEZE) begin
      res.status = ST_WRONG;
      return res;
    end
    // The lowest live slot holding the handle is the one addressed.
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pool_live[i] && pool_handle[i] == req.req_handle) hit = i;
    end
    if (hit < 0) begin
      res.status = ST_UNKNOWN;
      return res;
    end
    case (req.req_type)
      REQ_RELEASE: begin
        if (!pool_owned[hit]) begin
          res.status = ST_WRONG;
          return res;
        end
        pool_owned[hit] = 1'b0;
        pool_mapped[hit] = 1'b1;
      end
      REQ_DISCARD: begin
        res.out_capacity = pool_size[hit];
        pool_live[hit] = 1'b0;
        pool_owned[hit] = 1'b0;
        pool_frozen[hit] = 1'b0;
        pool_mapped[hit] = 1'b0;
        return res;
      end
      REQ_FREEZE: begin
        if (pool_frozen[hit]) begin
          res.status = ST_WRONG;
          return res;
        end
        pool_frozen[hit] = 1'b1;
      end
      default: begin
        if (!pool_frozen[hit]) begin
          res.status = ST_WRONG;
          return res;
        end
        pool_frozen[hit] = 1'b0;
      end
    endcase
    res.out_capacity = pool_size[hit];
    res.already_mapped = pool_mapped[hit];
    return res;
  endfunction

  // Finds the handle of a live slot in the wanted state, starting at a random slot.
  function automatic bit pick_pool_handle(pick_t mode, output logic [HANDLE_W-1:0] handle);
    int idx;
    int start;
    bit ok;
    handle = '0;
    start = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      idx = (start + n) % SLOTS;
      case (mode)
        PICK_OWNED:  ok = pool_owned[idx];
        PICK_FROZEN: ok = pool_frozen[idx];
        PICK_THAWED: ok = !pool_frozen[idx];
        default:     ok = 1'b1;
      endcase
      if (pool_live[idx] && ok) begin
        handle = pool_handle[idx];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bap_in_t random_request(int unsigned get_pct);
    bap_in_t req;
    int unsigned roll;
    pick_t mode;
    logic [HANDLE_W-1:0] found;
    roll = $urandom_range(0, 99);
    if (roll < 40) req.req_capacity = CAP_W'($urandom_range(0, 15));
    else if (roll < 70) req.req_capacity = {4'($urandom_range(0, 15)), 16'h0000};
    else if (roll < 90) req.req_capacity = CAP_W'($urandom);
    else req.req_capacity = '1;
    mode = PICK_ANY;
    if ($urandom_range(0, 99) < get_pct) begin
      req.req_type = REQ_GET;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        req.req_type = REQ_RELEASE;
        mode = PICK_OWNED;
      end else if (roll < 50) begin
        req.req_type = REQ_DISCARD;
      end else if (roll < 70) begin
        req.req_type = REQ_FREEZE;
        mode = PICK_THAWED;
      end else if (roll < 92) begin
        req.req_type = REQ_UNFREEZE;
        mode = PICK_FROZEN;
      end else begin
        req.req_type = 3'($urandom_range(REQ_UNFREEZE + 1, REQ_UNDEFINED));
      end
    end
    // Mostly handles the pool holds, sometimes recent or arbitrary ones.
    req.req_handle = $urandom;
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      if (pick_pool_handle(mode, found) || pick_pool_handle(PICK_ANY, found))
        req.req_handle = found;
    end else if (roll == 8) begin
      req.req_handle = last_handle - HANDLE_W'($urandom_range(0, 4));
    end
    return req;
  endfunction

  function automatic bap_in_t make_req(logic [2:0] kind, logic [CAP_W-1:0] cap,
                                       logic [HANDLE_W-1:0] handle);
    bap_in_t req;
    req.req_type = kind;
    req.req_capacity = cap;
    req.req_handle = handle;
    return req;
  endfunction

  // Leaves in_valid high after acceptance so back-to-back transactions need no toggle.
  task automatic send_request(bap_in_t req);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0)
      pending_results.push_back(predict_result(in_data));
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      stall_budget = out_idle_on ? $urandom_range(0, 14) : 0;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: handle %h cap %h mapped %b status %0d",
                   $time, out_data.out_handle, out_data.out_capacity,
                   out_data.already_mapped, out_data.status);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.out_handle !== oldest_result.out_handle ||
            out_data.out_capacity !== oldest_result.out_capacity ||
            out_data.already_mapped !== oldest_result.already_mapped ||
            out_data.status !== oldest_result.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected handle %h cap %h mapped %b status %0d, got %h %h %b %0d",
                     $time, oldest_result.out_handle, oldest_result.out_capacity,
                     oldest_result.already_mapped, oldest_result.status,
                     out_data.out_handle, out_data.out_capacity,
                     out_data.already_mapped, out_data.status);
        end
      end
    end
  end

  // A waiting result is held off by the drawn budget; otherwise stall at random when idling.
  always @(negedge clk) begin
    if (out_valid === 1'b1 && stall_budget > 0) begin
      out_stall = 1'b1;
      stall_budget = stall_budget - 1;
    end else if (out_valid !== 1'b1 && out_idle_on) begin
      out_stall = 1'($urandom_range(0, 1));
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic test_get_extremes();
    send_request(make_req(REQ_GET, '0, '0));
    send_request(make_req(REQ_GET, '1, '1));
  endtask

  task automatic test_release_and_reuse();
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 1));
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 1));
    send_request(make_req(REQ_GET, '0, '0));
  endtask

  task automatic test_unknown_handle();
    send_request(make_req(REQ_RELEASE, '1, '1));
    send_request(make_req(REQ_FREEZE, '0, '0));
  endtask

  task automatic test_freeze_toggle();
    send_request(make_req(REQ_FREEZE, '0, HANDLE_BASE + 2));
    send_request(make_req(REQ_FREEZE, '0, HANDLE_BASE + 2));
    send_request(make_req(REQ_UNFREEZE, '0, HANDLE_BASE + 2));
    send_request(make_req(REQ_UNFREEZE, '0, HANDLE_BASE + 2));
  endtask

  // An owned slot may be discarded; afterwards its handle is unknown.
  task automatic test_discard();
    send_request(make_req(REQ_DISCARD, '0, HANDLE_BASE + 1));
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 1));
  endtask

  task automatic test_undefined_type();
    send_request(make_req(REQ_UNDEFINED, '1, HANDLE_BASE + 2));
    send_request(make_req(REQ_UNFREEZE + 1, '0, '0));
  endtask

  // Two idle slots of equal size go to the lower one; a larger idle slot then wins over the one left.
  task automatic test_best_fit();
    send_request(make_req(REQ_GET, 20'd9, '0));
    send_request(make_req(REQ_GET, 20'd9, '0));
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 3));
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 4));
    send_request(make_req(REQ_GET, 20'd3, '0));
    send_request(make_req(REQ_RELEASE, '0, HANDLE_BASE + 2));
    send_request(make_req(REQ_GET, 20'd5, '0));
  endtask

  // Twenty gets in a row, more than the pool has slots, to run the pool out of slots.
  task automatic test_pool_exhaustion();
    repeat (20) send_request(random_request(100));
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned get_pct,
                                     bit idle_in, bit idle_out);
    in_idle_on = idle_in;
    out_idle_on = idle_out;
    repeat (count) send_request(random_request(get_pct));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    test_get_extremes();
    test_release_and_reuse();
    test_unknown_handle();
    test_freeze_toggle();
    test_discard();
    test_undefined_type();
    test_best_fit();
    test_pool_exhaustion();
    test_random_traffic(500, 45, 1'b1, 1'b1);
    drain_results();
    test_random_traffic(420, 40, 1'b0, 1'b0);
    test_random_traffic(500, 35, 1'b1, 1'b0);
    drain_results();
    test_random_traffic(490, 50, 1'b0, 1'b1);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results missing", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bap_pkg.sv
hw/rtl/bap_cell.sv
hw/rtl/buffer_pool_slot_allocator.sv
tb/tb.sv
